/* sv/packet_link_stats_monitor_top_defines.svh */
// Assertion macros used by the link statistics monitor checker.
`ifndef PACKET_LINK_STATS_MONITOR_TOP_DEFINES_SVH
`define PACKET_LINK_STATS_MONITOR_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define PLS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PLS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/pls_pkg.sv */
// Shared types and constants of the packet link statistics monitor.
package pls_pkg;

  localparam logic [1:0] REQ_PACKET = 2'd0;
  localparam logic [1:0] REQ_TICK   = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam logic [1:0] END_RUNNING = 2'd0;
  localparam logic [1:0] END_TIMEOUT = 2'd1;
  localparam logic [1:0] END_SILENCE = 2'd2;
  localparam logic [1:0] END_MARKER  = 2'd3;

  localparam logic [31:0] END_MARK   = 32'hDEADBEEF;
  localparam logic [31:0] NO_SEQ     = 32'hFFFFFFFF;
  localparam logic [31:0] QUIET_MAX  = 32'hFFFFFFFF;
  localparam logic signed [7:0] RSSI_FLOOR = -8'sd128;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_LIMIT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] LISTEN_LIMIT_RST  = 16'd15000;
  localparam logic [CFG_DATA_W-1:0] SILENCE_LIMIT_RST = 16'd3000;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [31:0]       seq_word;
    logic [31:0]       tail_word;
    logic signed [7:0] rssi;
  } pls_item_t;

  typedef struct packed {
    logic [1:0]        end_reason;
    logic [31:0]       window_received;
    logic [31:0]       cumulative_received;
    logic [31:0]       unique_count;
    logic [31:0]       duplicate_count;
    logic [31:0]       lost_count;
    logic [31:0]       total_expected;
    logic signed [7:0] rssi_low;
    logic signed [7:0] rssi_high;
    logic signed [31:0] rssi_total;
    logic [15:0]       rssi_samples;
    logic [31:0]       session_age_ms;
  } pls_result_t;

endpackage

/* sv/packet_link_stats_monitor_top.sv */
// Top level of the packet link statistics monitor.
//
//   Port group | Direction | Handshake          | Payload
//   in_        | request   | in_valid/in_stall  | pls_item_t
//   out_       | result    | out_valid/out_stall| pls_result_t
//   cfg_       | write     | cfg_we             | cfg_idx, cfg_wdata
//
// One request is accepted per cycle while in_stall is low; its result leaves on out_.
// The request register feeds the session update, whose result is held in a two-entry buffer.
// Reset is synchronous and active low and restores all limits and session state.
// While out_stall holds, the result register, the skid entry and the request register
// each absorb one request before in_stall rises.
module packet_link_stats_monitor_top import pls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pls_item_t             in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pls_result_t           out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic        req_v_r;
  pls_item_t   req_r;
  logic        q_full;
  logic        fire;
  pls_result_t res;

  assign fire     = req_v_r && !q_full;
  assign in_stall = req_v_r && q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_v_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_v_r <= 1'b1;
    end else if (fire) begin
      req_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_item;
    end
  end

  pls_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (req_r),
    .res       (res)
  );

  pls_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_data (res),
    .full      (q_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* sv/pls_core.sv */
// Session state, configuration registers and combinational result computation.
module pls_core import pls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  fire,
  input  pls_item_t             item,
  output pls_result_t           res
);

  logic [CFG_DATA_W-1:0] listen_limit_r;
  logic [CFG_DATA_W-1:0] silence_limit_r;

  logic [31:0]        win_cnt_r,   win_cnt_nxt;
  logic [31:0]        all_cnt_r,   all_cnt_nxt;
  logic [31:0]        uniq_cnt_r,  uniq_cnt_nxt;
  logic [31:0]        dup_cnt_r,   dup_cnt_nxt;
  logic [31:0]        prev_seq_r,  prev_seq_nxt;
  logic [31:0]        high_seq_r,  high_seq_nxt;
  logic [31:0]        sender_r,    sender_nxt;
  logic [31:0]        sess_ms_r,   sess_ms_nxt;
  logic [31:0]        quiet_ms_r,  quiet_ms_nxt;
  logic signed [31:0] rssi_sum_r,  rssi_sum_nxt;
  logic signed [7:0]  rssi_min_r,  rssi_min_nxt;
  logic signed [7:0]  rssi_max_r,  rssi_max_nxt;
  logic [15:0]        rssi_cnt_r,  rssi_cnt_nxt;
  logic [1:0]         finish_r,    finish_nxt;

  logic [31:0] total;
  logic [31:0] lost;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_limit_r  <= LISTEN_LIMIT_RST;
      silence_limit_r <= SILENCE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_LISTEN_LIMIT:  listen_limit_r  <= cfg_wdata;
        CFG_SILENCE_LIMIT: silence_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    win_cnt_nxt  = win_cnt_r;
    all_cnt_nxt  = all_cnt_r;
    uniq_cnt_nxt = uniq_cnt_r;
    dup_cnt_nxt  = dup_cnt_r;
    prev_seq_nxt = prev_seq_r;
    high_seq_nxt = high_seq_r;
    sender_nxt   = sender_r;
    sess_ms_nxt  = sess_ms_r;
    quiet_ms_nxt = quiet_ms_r;
    rssi_sum_nxt = rssi_sum_r;
    rssi_min_nxt = rssi_min_r;
    rssi_max_nxt = rssi_max_r;
    rssi_cnt_nxt = rssi_cnt_r;
    finish_nxt   = finish_r;
    if (fire) begin
      unique case (item.req_type)
        REQ_START: begin
          win_cnt_nxt  = '0;
          uniq_cnt_nxt = '0;
          dup_cnt_nxt  = '0;
          prev_seq_nxt = NO_SEQ;
          high_seq_nxt = '0;
          sender_nxt   = '0;
          sess_ms_nxt  = '0;
          quiet_ms_nxt = '0;
          rssi_sum_nxt = '0;
          rssi_min_nxt = '0;
          rssi_max_nxt = RSSI_FLOOR;
          rssi_cnt_nxt = '0;
          finish_nxt   = END_RUNNING;
        end
        REQ_TICK: begin
          if (finish_r == END_RUNNING) begin
            sess_ms_nxt = sess_ms_r + 32'd1;
            if (quiet_ms_r != QUIET_MAX) begin
              quiet_ms_nxt = quiet_ms_r + 32'd1;
            end
            if (sess_ms_nxt >= {16'd0, listen_limit_r}) begin
              finish_nxt = END_TIMEOUT;
            end else if ((win_cnt_r != '0) && (quiet_ms_nxt >= {16'd0, silence_limit_r})) begin
              finish_nxt = END_SILENCE;
            end
          end
        end
        REQ_PACKET: begin
          if (finish_r == END_RUNNING) begin
            rssi_sum_nxt = rssi_sum_r + 32'(item.rssi);
            rssi_cnt_nxt = rssi_cnt_r + 16'd1;
            if (item.rssi < rssi_min_r) begin
              rssi_min_nxt = item.rssi;
            end
            if (item.rssi > rssi_max_r) begin
              rssi_max_nxt = item.rssi;
            end
            if (item.seq_word == END_MARK) begin
              sender_nxt = item.tail_word;
              finish_nxt = END_MARKER;
            end else begin
              win_cnt_nxt = win_cnt_r + 32'd1;
              all_cnt_nxt = all_cnt_r + 32'd1;
              if ((prev_seq_r != NO_SEQ) && (item.seq_word == prev_seq_r)) begin
                dup_cnt_nxt = dup_cnt_r + 32'd1;
              end else begin
                uniq_cnt_nxt = uniq_cnt_r + 32'd1;
              end
              prev_seq_nxt = item.seq_word;
              if (item.seq_word > high_seq_r) begin
                high_seq_nxt = item.seq_word;
              end
              quiet_ms_nxt = '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r  <= '0;
      all_cnt_r  <= '0;
      uniq_cnt_r <= '0;
      dup_cnt_r  <= '0;
      prev_seq_r <= NO_SEQ;
      high_seq_r <= '0;
      sender_r   <= '0;
      sess_ms_r  <= '0;
      quiet_ms_r <= '0;
      rssi_sum_r <= '0;
      rssi_min_r <= '0;
      rssi_max_r <= RSSI_FLOOR;
      rssi_cnt_r <= '0;
      finish_r   <= END_TIMEOUT;
    end else begin
      win_cnt_r  <= win_cnt_nxt;
      all_cnt_r  <= all_cnt_nxt;
      uniq_cnt_r <= uniq_cnt_nxt;
      dup_cnt_r  <= dup_cnt_nxt;
      prev_seq_r <= prev_seq_nxt;
      high_seq_r <= high_seq_nxt;
      sender_r   <= sender_nxt;
      sess_ms_r  <= sess_ms_nxt;
      quiet_ms_r <= quiet_ms_nxt;
      rssi_sum_r <= rssi_sum_nxt;
      rssi_min_r <= rssi_min_nxt;
      rssi_max_r <= rssi_max_nxt;
      rssi_cnt_r <= rssi_cnt_nxt;
      finish_r   <= finish_nxt;
    end
  end

  assign total = (sender_nxt != '0) ? sender_nxt : (high_seq_nxt + 32'd1);
  assign lost  = (total > all_cnt_nxt) ? (total - all_cnt_nxt) : '0;

  always_comb begin
    res.end_reason          = finish_nxt;
    res.window_received     = win_cnt_nxt;
    res.cumulative_received = all_cnt_nxt;
    res.unique_count        = uniq_cnt_nxt;
    res.duplicate_count     = dup_cnt_nxt;
    res.lost_count          = lost;
    res.total_expected      = total;
    res.rssi_low            = rssi_min_nxt;
    res.rssi_high           = rssi_max_nxt;
    res.rssi_total          = rssi_sum_nxt;
    res.rssi_samples        = rssi_cnt_nxt;
    res.session_age_ms      = sess_ms_nxt;
  end

endmodule

/* sv/pls_outq.sv */
// Two-entry result buffer: output register plus skid register.
module pls_outq import pls_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  pls_result_t push_data,
  output logic        full,
  output logic        out_valid,
  input  logic        out_stall,
  output pls_result_t out_data
);

  logic        head_v_r;
  logic        skid_v_r;
  pls_result_t head_r;
  pls_result_t skid_r;
  logic        pop;

  assign pop       = head_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = head_v_r;
  assign out_data  = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_v_r) begin
          head_v_r <= 1'b1;
          skid_v_r <= push;
        end else begin
          head_v_r <= push;
        end
      end else if (push) begin
        if (head_v_r) begin
          skid_v_r <= 1'b1;
        end else begin
          head_v_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_v_r) begin
        head_r <= skid_r;
        if (push) begin
          skid_r <= push_data;
        end
      end else if (push) begin
        head_r <= push_data;
      end
    end else if (push) begin
      if (head_v_r) begin
        skid_r <= push_data;
      end else begin
        head_r <= push_data;
      end
    end
  end

endmodule

/* sv/pls_checker.sv */
// Port-level checker of the packet link statistics monitor and its bind.
`include "packet_link_stats_monitor_top_defines.svh"

module pls_checker import pls_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input pls_result_t out_data
);

  `PLS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `PLS_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid && !in_stall, "buffer not empty after reset")
  `PLS_ASSERT(a_stall_needs_result, in_stall |-> out_valid, "request stalled with no result pending")
  `PLS_ASSERT(a_stall_cause, $rose(in_stall) |-> $past(out_stall), "request stall without result stall")

endmodule

bind packet_link_stats_monitor_top pls_checker u_pls_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* tb/sv/link_stats_scoreboard_pkg.sv */
// Scoreboard class that predicts and checks the link statistics monitor results.
`timescale 1ns / 1ps

package link_stats_tb_pkg;
  import pls_pkg::*;

  class link_stats_scoreboard;
    pls_result_t expected_q[$];
    int unsigned mismatch_count;

    logic [CFG_DATA_W-1:0] listen_limit;
    logic [CFG_DATA_W-1:0] silence_limit;

    logic [31:0]        window_count;
    logic [31:0]        all_count;
    logic [31:0]        distinct_count;
    logic [31:0]        repeat_count;
    logic [31:0]        prev_seq;
    logic [31:0]        top_seq;
    logic [31:0]        sender_total;
    logic [31:0]        session_ms;
    logic [31:0]        quiet_ms;
    logic signed [31:0] strength_sum;
    logic signed [7:0]  strength_min;
    logic signed [7:0]  strength_max;
    logic [15:0]        strength_count;
    logic [1:0]         finish_code;

    function new();
      mismatch_count = 0;
      listen_limit   = LISTEN_LIMIT_RST;
      silence_limit  = SILENCE_LIMIT_RST;
      clear_session();
      all_count      = '0;
      finish_code    = END_TIMEOUT;
    endfunction

    function void clear_session();
      window_count   = '0;
      distinct_count = '0;
      repeat_count   = '0;
      prev_seq       = NO_SEQ;
      top_seq        = '0;
      sender_total   = '0;
      session_ms     = '0;
      quiet_ms       = '0;
      strength_sum   = '0;
      strength_min   = '0;
      strength_max   = RSSI_FLOOR;
      strength_count = '0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
      if (idx == CFG_LISTEN_LIMIT) begin
        listen_limit = value;
      end else begin
        silence_limit = value;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Updates the session figures for one accepted request and queues the
    // result it must produce. Returns whether the request had any effect.
    function bit note_request(pls_item_t req);
      pls_result_t       want;
      logic [31:0]       total;
      logic signed [7:0] level;
      bit                live;
      live = 1'b0;
      case (req.req_type)
        REQ_START: begin
          clear_session();
          finish_code = END_RUNNING;
          live = 1'b1;
        end
        REQ_TICK: if (finish_code == END_RUNNING) begin
          live = 1'b1;
          session_ms = session_ms + 32'd1;
          if (quiet_ms != QUIET_MAX) begin
            quiet_ms = quiet_ms + 32'd1;
          end
          if (session_ms >= {16'd0, listen_limit}) begin
            finish_code = END_TIMEOUT;
          end else if (window_count != 0 && quiet_ms >= {16'd0, silence_limit}) begin
            finish_code = END_SILENCE;
          end
        end
        REQ_PACKET: if (finish_code == END_RUNNING) begin
          live = 1'b1;
          level = req.rssi;
          strength_sum = strength_sum + 32'(level);
          strength_count = strength_count + 16'd1;
          if (level < strength_min) begin
            strength_min = level;
          end
          if (level > strength_max) begin
            strength_max = level;
          end
          if (req.seq_word == END_MARK) begin
            sender_total = req.tail_word;
            finish_code = END_MARKER;
          end else begin
            window_count = window_count + 32'd1;
            all_count = all_count + 32'd1;
            if (prev_seq != NO_SEQ && req.seq_word == prev_seq) begin
              repeat_count = repeat_count + 32'd1;
            end else begin
              distinct_count = distinct_count + 32'd1;
            end
            prev_seq = req.seq_word;
            if (req.seq_word > top_seq) begin
              top_seq = req.seq_word;
            end
            quiet_ms = '0;
          end
        end
        default: begin
        end
      endcase

      total = (sender_total != 0) ? sender_total : top_seq + 32'd1;
      want.end_reason          = finish_code;
      want.window_received     = window_count;
      want.cumulative_received = all_count;
      want.unique_count        = distinct_count;
      want.duplicate_count     = repeat_count;
      want.lost_count          = (total > all_count) ? total - all_count : 32'd0;
      want.total_expected      = total;
      want.rssi_low            = strength_min;
      want.rssi_high           = strength_max;
      want.rssi_total          = strength_sum;
      want.rssi_samples        = strength_count;
      want.session_age_ms      = session_ms;
      expected_q.push_back(want);
      return live;
    endfunction

    function void compare_field(string name, logic signed [32:0] want_v,
                                logic signed [32:0] got_v);
      if (got_v !== want_v) begin
        mismatch_count++;
        $error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
      end
    endfunction

    function void check_result(pls_result_t got);
      pls_result_t want;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        $error("Result arrived with no request outstanding.");
        return;
      end
      want = expected_q.pop_front();
      compare_field("end_reason", want.end_reason, got.end_reason);
      compare_field("window_received", want.window_received, got.window_received);
      compare_field("cumulative_received", want.cumulative_received,
                    got.cumulative_received);
      compare_field("unique_count", want.unique_count, got.unique_count);
      compare_field("duplicate_count", want.duplicate_count, got.duplicate_count);
      compare_field("lost_count", want.lost_count, got.lost_count);
      compare_field("total_expected", want.total_expected, got.total_expected);
      compare_field("rssi_low", want.rssi_low, got.rssi_low);
      compare_field("rssi_high", want.rssi_high, got.rssi_high);
      compare_field("rssi_total", want.rssi_total, got.rssi_total);
      compare_field("rssi_samples", want.rssi_samples, got.rssi_samples);
      compare_field("session_age_ms", want.session_age_ms, got.session_age_ms);
    endfunction
  endclass

endpackage

/* tb/sv/tb_packet_link_stats_monitor_top.sv */
// Testbench top that drives requests, limits and result stalls into the monitor.
`timescale 1ns / 1ps

module tb_packet_link_stats_monitor_top;
  import pls_pkg::*;
  import link_stats_tb_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 235;
  localparam int RANDOM_PHASES   = 8;
  localparam int SETTLE_CYCLES   = 4;
  localparam int IDLE_LIMIT      = 4000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  pls_item_t             in_item;
  logic                  out_valid;
  logic                  out_stall;
  pls_result_t           out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  link_stats_scoreboard sb = new();
  bit                   calm_stretch;
  logic [31:0]          next_seq;
  int                   idle_cycles;

  packet_link_stats_monitor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_stretch || roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Most requests follow a live session: counting sequences with some repeats,
  // skips and wraps, ticks, and an occasional end marker. The rest is noise.
  function automatic pls_item_t make_request();
    pls_item_t req;
    int        roll;
    req.req_type  = REQ_PACKET;
    req.seq_word  = $urandom();
    req.tail_word = $urandom();
    req.rssi      = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    if (sb.finish_code != END_RUNNING) begin
      if (roll < 85) begin
        req.req_type = REQ_START;
      end else begin
        req.req_type = 2'($urandom_range(0, 3));
      end
    end else if (roll < 50) begin
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
        req.seq_word = next_seq;
      end else if (roll < 87) begin
        req.seq_word = sb.prev_seq;
      end else if (roll < 93) begin
        req.seq_word = next_seq + $urandom_range(2, 20);
      end else if (roll >= 97) begin
        req.seq_word = NO_SEQ;
      end
      next_seq = req.seq_word + 32'd1;
    end else if (roll < 86) begin
      req.req_type = REQ_TICK;
    end else if (roll < 89) begin
      req.seq_word = END_MARK;
      roll = $urandom_range(0, 2);
      if (roll == 0) begin
        req.tail_word = '0;
      end else if (roll == 1) begin
        req.tail_word = next_seq + $urandom_range(0, 10);
      end
    end else if (roll < 91) begin
      req.req_type = REQ_UNUSED;
    end else if (roll < 93) begin
      req.req_type = REQ_START;
    end else begin
      req.req_type = 2'($urandom_range(0, 3));
    end
    if (req.req_type == REQ_START) begin
      next_seq = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 50);
    end
    return req;
  endfunction

  task automatic send_request(input pls_item_t req, output bit live);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= req;
    do @(posedge clk); while (in_stall);
    live = sb.note_request(req);
  endtask

  task automatic send_fields(input logic [1:0] kind, input logic [31:0] seq,
                             input logic [31:0] tail, input logic signed [7:0] level);
    pls_item_t req;
    bit        live;
    req.req_type  = kind;
    req.seq_word  = seq;
    req.tail_word = tail;
    req.rssi      = level;
    send_request(req, live);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limits(input logic [CFG_DATA_W-1:0] listen,
                              input logic [CFG_DATA_W-1:0] silence);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_LISTEN_LIMIT;
    cfg_wdata <= listen;
    @(posedge clk);
    cfg_idx   <= CFG_SILENCE_LIMIT;
    cfg_wdata <= silence;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_limit(CFG_LISTEN_LIMIT, listen);
    sb.set_limit(CFG_SILENCE_LIMIT, silence);
  endtask

  initial begin : result_sink
    int hold;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_data);
      end
      if (hold > 0) begin
        hold--;
      end else begin
        hold = pick_gap();
      end
      out_stall <= (hold > 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    pls_item_t req;
    bit        live;
    int        live_count;
    logic [CFG_DATA_W-1:0] listen;
    logic [CFG_DATA_W-1:0] silence;
    calm_stretch = 1'b0;
    next_seq     = '0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Requests before the first start are ignored; then duplicates, the
    // all-ones sequence, end markers with and without a sender total, and
    // requests after the session has ended.
    send_fields(REQ_PACKET, 32'd1, 32'd0, 8'sd5);
    send_fields(REQ_TICK, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_UNUSED, NO_SEQ, NO_SEQ, -8'sd1);
    send_fields(REQ_START, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_PACKET, 32'd0, 32'd0, RSSI_FLOOR);
    send_fields(REQ_PACKET, 32'd0, NO_SEQ, 8'sd127);
    send_fields(REQ_PACKET, NO_SEQ, 32'd0, 8'sd0);
    send_fields(REQ_PACKET, NO_SEQ, 32'd0, -8'sd1);
    send_fields(REQ_PACKET, 32'hFFFFFFFE, 32'd0, 8'sd1);
    send_fields(REQ_TICK, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_UNUSED, NO_SEQ, NO_SEQ, -8'sd1);
    send_fields(REQ_PACKET, END_MARK, NO_SEQ, 8'sd127);
    send_fields(REQ_PACKET, 32'd7, 32'd0, 8'sd0);
    send_fields(REQ_TICK, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_START, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_PACKET, END_MARK, 32'd0, RSSI_FLOOR);
    send_fields(REQ_START, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_PACKET, 32'd5, 32'd0, 8'sd3);
    settle();

    // Timeout and silence fall due on the same tick; timeout must win.
    write_limits(16'd1, 16'd1);
    send_fields(REQ_START, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_PACKET, 32'd9, 32'd0, -8'sd60);
    send_fields(REQ_TICK, 32'd0, 32'd0, 8'sd0);
    settle();

    write_limits(16'd0, 16'd0);
    send_fields(REQ_START, 32'd0, 32'd0, 8'sd0);
    send_fields(REQ_TICK, 32'd0, 32'd0, 8'sd0);
    settle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          listen = 16'hFFFF;
          silence = 16'hFFFF;
        end
        1: begin
          listen = 16'hFFFF;
          silence = 16'd1;
        end
        2: begin
          listen = 16'd1;
          silence = 16'hFFFF;
        end
        3: begin
          listen = 16'd6;
          silence = 16'd0;
        end
        default: begin
          listen = 16'($urandom_range(2, 400));
          silence = 16'($urandom_range(1, 40));
        end
      endcase
      write_limits(listen, silence);
      live_count = 0;
      while (live_count < ITEMS_PER_PHASE) begin
        req = make_request();
        send_request(req, live);
        if (live) begin
          live_count++;
          if (live_count % 50 == 0) begin
            calm_stretch = ($urandom_range(0, 3) == 0);
          end
        end
      end
      calm_stretch = 1'b0;
      settle();
    end

    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/pls_pkg.sv
sv/pls_core.sv
sv/pls_outq.sv
sv/packet_link_stats_monitor_top.sv
sv/pls_checker.sv
tb/sv/link_stats_scoreboard_pkg.sv
tb/sv/tb_packet_link_stats_monitor_top.sv
